/* sv/rtp_header_parser_core_assert.svh */
// Assertion macros shared by the RTP header parser RTL.
// Each macro expects clk and arst_n in the scope where it is used.
`ifndef RTP_HEADER_PARSER_CORE_ASSERT_SVH
`define RTP_HEADER_PARSER_CORE_ASSERT_SVH
`ifndef NO_ASSERTIONS
`define RHP_ASSERT_IMPL(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);
`define RHP_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);
`else
`define RHP_ASSERT_IMPL(lbl, ante, cons, msg)
`define RHP_ASSERT_NEXT(lbl, ante, cons, msg)
`endif
`endif

/* sv/rhp_pkg.sv */
// Types and constants of the RTP header parser.
// Used by rhp_front, rhp_queue, rhp_back and rtp_header_parser_core.
package rhp_pkg;

	localparam int RHP_QDEPTH = 4;
	localparam int RHP_QPTR_W = $clog2(RHP_QDEPTH);
	localparam int RHP_QCNT_W = $clog2(RHP_QDEPTH + 1);

	localparam logic [1:0] KIND_HEADER  = 2'd0;
	localparam logic [1:0] KIND_CSRC    = 2'd1;
	localparam logic [1:0] KIND_PAYLOAD = 2'd2;
	localparam logic [1:0] KIND_ERROR   = 2'd3;

	localparam logic [1:0] ERR_SHORT   = 2'd0;
	localparam logic [1:0] ERR_VERSION = 2'd1;
	localparam logic [1:0] ERR_TRUNC   = 2'd2;

	localparam logic [1:0] RTP_VERSION = 2'd2;
	localparam logic [3:0] HDR_LAST_IDX = 4'd11;
	localparam logic [3:0] HDR_SHIFT_BYTES = 4'd8;
	localparam logic [3:0] WORD_LAST_IDX = 4'd3;

	// one classified beat from the front to the back
	typedef struct packed {
		logic [1:0]  kind;
		logic [1:0]  err;
		logic        last;
		logic [31:0] value;
		logic [63:0] hdr;
	} rhp_rec_t;

endpackage

/* sv/rhp_front.sv */
// Front part of the RTP header parser: byte-level parse state machine.
// Depends on rhp_pkg and rtp_header_parser_core_assert.svh.
`include "rtp_header_parser_core_assert.svh"
module rhp_front (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             accept,
	input  logic [7:0]       data_byte,
	input  logic             last_byte,
	output logic             rec_valid,
	output rhp_pkg::rhp_rec_t rec
);

	typedef enum logic [2:0] {
		PH_HEADER  = 3'd0,
		PH_CSRC    = 3'd1,
		PH_EXTHDR  = 3'd2,
		PH_EXTDATA = 3'd3,
		PH_PAYLOAD = 3'd4,
		PH_DROP    = 3'd5
	} phase_t;

	phase_t      phase_q, phase_d;
	logic [3:0]  idx_q, idx_d;
	logic [63:0] hdr_q, hdr_d;
	logic [23:0] wa_q, wa_d;
	logic [3:0]  csrc_q, csrc_d;
	logic [15:0] ext_q, ext_d;

	logic [31:0] word;
	logic [3:0]  csrc_dec;
	logic [15:0] ext_dec;
	logic [15:0] ext_len;
	logic [7:0]  b0;
	logic        x_bit;
	logic [3:0]  cc;
	logic        err_set;
	logic [1:0]  err_code;
	logic        restart;

	assign word     = {wa_q, data_byte};
	assign csrc_dec = csrc_q - 4'd1;
	assign ext_dec  = ext_q - 16'd1;
	assign ext_len  = {wa_q[7:0], data_byte};
	assign b0       = hdr_q[63:56];
	assign x_bit    = hdr_q[60];
	assign cc       = hdr_q[59:56];

	always_comb begin
		phase_d   = phase_q;
		idx_d     = idx_q;
		hdr_d     = hdr_q;
		wa_d      = wa_q;
		csrc_d    = csrc_q;
		ext_d     = ext_q;
		rec_valid = 1'b0;
		rec       = '0;
		rec.hdr   = hdr_q;
		rec.last  = last_byte;
		err_set   = 1'b0;
		err_code  = rhp_pkg::ERR_SHORT;
		restart   = 1'b0;
		if (accept) begin
			unique case (phase_q)
				PH_HEADER: begin
					if (idx_q < rhp_pkg::HDR_LAST_IDX) begin
						if (idx_q < rhp_pkg::HDR_SHIFT_BYTES) begin
							hdr_d = {hdr_q[55:0], data_byte};
						end else begin
							wa_d = {wa_q[15:0], data_byte};
						end
						if (last_byte) begin
							err_set  = 1'b1;
							err_code = rhp_pkg::ERR_SHORT;
						end else begin
							idx_d = idx_q + 4'd1;
						end
					end else if (b0[7:6] != rhp_pkg::RTP_VERSION) begin
						err_set  = 1'b1;
						err_code = rhp_pkg::ERR_VERSION;
					end else if (last_byte && (cc != 4'd0 || x_bit)) begin
						err_set  = 1'b1;
						err_code = rhp_pkg::ERR_TRUNC;
					end else begin
						rec_valid = 1'b1;
						rec.kind  = rhp_pkg::KIND_HEADER;
						rec.value = word;
						if (last_byte) begin
							restart = 1'b1;
						end else begin
							idx_d  = 4'd0;
							wa_d   = '0;
							csrc_d = cc;
							if (cc != 4'd0) begin
								phase_d = PH_CSRC;
							end else if (x_bit) begin
								phase_d = PH_EXTHDR;
							end else begin
								phase_d = PH_PAYLOAD;
							end
						end
					end
				end
				PH_CSRC: begin
					if (idx_q < rhp_pkg::WORD_LAST_IDX) begin
						wa_d = {wa_q[15:0], data_byte};
						if (last_byte) begin
							err_set  = 1'b1;
							err_code = rhp_pkg::ERR_TRUNC;
						end else begin
							idx_d = idx_q + 4'd1;
						end
					end else begin
						csrc_d = csrc_dec;
						if (last_byte && (csrc_dec != 4'd0 || x_bit)) begin
							err_set  = 1'b1;
							err_code = rhp_pkg::ERR_TRUNC;
						end else begin
							rec_valid = 1'b1;
							rec.kind  = rhp_pkg::KIND_CSRC;
							rec.value = word;
							if (last_byte) begin
								restart = 1'b1;
							end else begin
								idx_d = 4'd0;
								wa_d  = '0;
								if (csrc_dec == 4'd0) begin
									phase_d = x_bit ? PH_EXTHDR : PH_PAYLOAD;
								end
							end
						end
					end
				end
				PH_EXTHDR: begin
					if (idx_q < rhp_pkg::WORD_LAST_IDX) begin
						wa_d = {wa_q[15:0], data_byte};
						if (last_byte) begin
							err_set  = 1'b1;
							err_code = rhp_pkg::ERR_TRUNC;
						end else begin
							idx_d = idx_q + 4'd1;
						end
					end else begin
						ext_d = ext_len;
						if (last_byte) begin
							if (ext_len != 16'd0) begin
								err_set  = 1'b1;
								err_code = rhp_pkg::ERR_TRUNC;
							end else begin
								restart = 1'b1;
							end
						end else begin
							idx_d   = 4'd0;
							wa_d    = '0;
							phase_d = (ext_len != 16'd0) ? PH_EXTDATA : PH_PAYLOAD;
						end
					end
				end
				PH_EXTDATA: begin
					if (idx_q < rhp_pkg::WORD_LAST_IDX) begin
						if (last_byte) begin
							err_set  = 1'b1;
							err_code = rhp_pkg::ERR_TRUNC;
						end else begin
							idx_d = idx_q + 4'd1;
						end
					end else begin
						ext_d = ext_dec;
						if (last_byte) begin
							if (ext_dec != 16'd0) begin
								err_set  = 1'b1;
								err_code = rhp_pkg::ERR_TRUNC;
							end else begin
								restart = 1'b1;
							end
						end else begin
							idx_d = 4'd0;
							if (ext_dec == 16'd0) begin
								phase_d = PH_PAYLOAD;
							end
						end
					end
				end
				PH_PAYLOAD: begin
					rec_valid = 1'b1;
					rec.kind  = rhp_pkg::KIND_PAYLOAD;
					rec.value = {24'd0, data_byte};
					restart   = last_byte;
				end
				default: begin
					restart = last_byte;
				end
			endcase
		end
		if (err_set) begin
			rec_valid = 1'b1;
			rec.kind  = rhp_pkg::KIND_ERROR;
			rec.err   = err_code;
			rec.value = '0;
			if (last_byte) begin
				restart = 1'b1;
			end else begin
				phase_d = PH_DROP;
			end
		end
		if (restart) begin
			phase_d = PH_HEADER;
			idx_d   = 4'd0;
			wa_d    = '0;
			csrc_d  = 4'd0;
			ext_d   = 16'd0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= PH_HEADER;
			idx_q   <= 4'd0;
			hdr_q   <= '0;
			wa_q    <= '0;
			csrc_q  <= 4'd0;
			ext_q   <= 16'd0;
		end else begin
			phase_q <= phase_d;
			idx_q   <= idx_d;
			hdr_q   <= hdr_d;
			wa_q    <= wa_d;
			csrc_q  <= csrc_d;
			ext_q   <= ext_d;
		end
	end

	`RHP_ASSERT_IMPL(a_csrc_phase, csrc_q != 4'd0, phase_q == PH_CSRC, "stray CSRC count")
	`RHP_ASSERT_IMPL(a_ext_phase, ext_q != 16'd0, phase_q == PH_EXTDATA, "stray ext count")
	`RHP_ASSERT_IMPL(a_no_beat_idle, !accept, !rec_valid, "beat without input byte")

endmodule

/* sv/rhp_queue.sv */
// Short queue of classified beats between the front and the back.
// Depends on rhp_pkg and rtp_header_parser_core_assert.svh.
`include "rtp_header_parser_core_assert.svh"
module rhp_queue (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              wr_en,
	input  rhp_pkg::rhp_rec_t wr_data,
	output logic              full,
	input  logic              rd_en,
	output rhp_pkg::rhp_rec_t rd_data,
	output logic              empty
);

	rhp_pkg::rhp_rec_t                 mem_q [rhp_pkg::RHP_QDEPTH];
	logic [rhp_pkg::RHP_QPTR_W-1:0]    wr_ptr_q;
	logic [rhp_pkg::RHP_QPTR_W-1:0]    rd_ptr_q;
	logic [rhp_pkg::RHP_QCNT_W-1:0]    count_q;
	logic                              do_wr;
	logic                              do_rd;

	assign full    = (count_q == rhp_pkg::RHP_QCNT_W'(rhp_pkg::RHP_QDEPTH));
	assign empty   = (count_q == '0);
	assign do_wr   = wr_en && !full;
	assign do_rd   = rd_en && !empty;
	assign rd_data = mem_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (do_wr) begin
			mem_q[wr_ptr_q] <= wr_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (do_wr) begin
				wr_ptr_q <= wr_ptr_q + rhp_pkg::RHP_QPTR_W'(1);
			end
			if (do_rd) begin
				rd_ptr_q <= rd_ptr_q + rhp_pkg::RHP_QPTR_W'(1);
			end
			if (do_wr && !do_rd) begin
				count_q <= count_q + rhp_pkg::RHP_QCNT_W'(1);
			end else if (do_rd && !do_wr) begin
				count_q <= count_q - rhp_pkg::RHP_QCNT_W'(1);
			end
		end
	end

	`RHP_ASSERT_IMPL(a_no_overflow, full, !do_wr, "write into a full queue")
	`RHP_ASSERT_NEXT(a_wr_shows, do_wr && !do_rd, !empty, "written beat not visible")

endmodule

/* sv/rhp_back.sv */
// Back part of the RTP header parser: unpacks beats into the result register.
// Depends on rhp_pkg and rtp_header_parser_core_assert.svh.
`include "rtp_header_parser_core_assert.svh"
module rhp_back (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              q_empty,
	input  rhp_pkg::rhp_rec_t q_data,
	output logic              q_pop,
	input  logic              pop,
	output logic              empty,
	output logic [1:0]        kind,
	output logic              padding_flag,
	output logic              extension_flag,
	output logic [3:0]        csrc_count,
	output logic              marker_flag,
	output logic [6:0]        payload_type,
	output logic [15:0]       sequence_number,
	output logic [31:0]       timestamp,
	output logic [31:0]       source_id,
	output logic [31:0]       item_value,
	output logic [1:0]        error_code,
	output logic              last_of_packet
);

	logic valid_q;
	logic is_hdr;

	assign empty  = !valid_q;
	assign q_pop  = !q_empty && (!valid_q || pop);
	assign is_hdr = (q_data.kind == rhp_pkg::KIND_HEADER);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (q_pop) begin
			valid_q <= 1'b1;
		end else if (pop) begin
			valid_q <= 1'b0;
		end
	end

	// advance the result register when it is free or being taken
	always_ff @(posedge clk) begin
		if (q_pop) begin
			kind            <= q_data.kind;
			padding_flag    <= is_hdr && q_data.hdr[61];
			extension_flag  <= is_hdr && q_data.hdr[60];
			csrc_count      <= is_hdr ? q_data.hdr[59:56] : 4'd0;
			marker_flag     <= is_hdr && q_data.hdr[55];
			payload_type    <= is_hdr ? q_data.hdr[54:48] : 7'd0;
			sequence_number <= is_hdr ? q_data.hdr[47:32] : 16'd0;
			timestamp       <= is_hdr ? q_data.hdr[31:0] : 32'd0;
			source_id       <= is_hdr ? q_data.value : 32'd0;
			item_value      <= (q_data.kind == rhp_pkg::KIND_CSRC ||
				q_data.kind == rhp_pkg::KIND_PAYLOAD) ? q_data.value : 32'd0;
			error_code      <= (q_data.kind == rhp_pkg::KIND_ERROR) ? q_data.err : 2'd0;
			last_of_packet  <= q_data.last;
		end
	end

	`RHP_ASSERT_IMPL(a_pop_nonempty, q_pop, !q_empty, "queue popped while empty")
	`RHP_ASSERT_NEXT(a_load_valid, q_pop, valid_q, "loaded result not shown")

endmodule

/* sv/rtp_header_parser_core.sv */
// Top level of the RTP header parser: front parser, beat queue, result stage.
// Depends on rhp_pkg, rhp_front, rhp_queue and rhp_back.
//
// Takes one RTP packet byte per clock while full is low, with a last-byte mark,
// and gives a header result after the twelfth byte, one result per CSRC word,
// one per payload byte (padding included) and error results for short,
// bad-version or truncated packets, after which the rest of the packet is
// dropped. A byte can be pushed in every cycle in which full is low: the front
// parser classifies each byte in the cycle it is taken and writes at most one
// beat into a four-entry queue, and the back stage moves beats into the result
// register. A result passes through the queue and then the result register
// before it reaches the result ports; full rises only when the result side has
// stopped popping and the queue and result register hold five beats.
module rtp_header_parser_core (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        push,
	output logic        full,
	input  logic [7:0]  data_byte,
	input  logic        last_byte,
	input  logic        pop,
	output logic        empty,
	output logic [1:0]  kind,
	output logic        padding_flag,
	output logic        extension_flag,
	output logic [3:0]  csrc_count,
	output logic        marker_flag,
	output logic [6:0]  payload_type,
	output logic [15:0] sequence_number,
	output logic [31:0] timestamp,
	output logic [31:0] source_id,
	output logic [31:0] item_value,
	output logic [1:0]  error_code,
	output logic        last_of_packet
);

	logic              accept;
	logic              rec_valid;
	rhp_pkg::rhp_rec_t rec;
	rhp_pkg::rhp_rec_t q_data;
	logic              q_empty;
	logic              q_pop;

	assign accept = push && !full;

	rhp_front u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.accept    (accept),
		.data_byte (data_byte),
		.last_byte (last_byte),
		.rec_valid (rec_valid),
		.rec       (rec)
	);

	rhp_queue u_queue (
		.clk     (clk),
		.arst_n  (arst_n),
		.wr_en   (rec_valid),
		.wr_data (rec),
		.full    (full),
		.rd_en   (q_pop),
		.rd_data (q_data),
		.empty   (q_empty)
	);

	rhp_back u_back (
		.clk             (clk),
		.arst_n          (arst_n),
		.q_empty         (q_empty),
		.q_data          (q_data),
		.q_pop           (q_pop),
		.pop             (pop),
		.empty           (empty),
		.kind            (kind),
		.padding_flag    (padding_flag),
		.extension_flag  (extension_flag),
		.csrc_count      (csrc_count),
		.marker_flag     (marker_flag),
		.payload_type    (payload_type),
		.sequence_number (sequence_number),
		.timestamp       (timestamp),
		.source_id       (source_id),
		.item_value      (item_value),
		.error_code      (error_code),
		.last_of_packet  (last_of_packet)
	);

endmodule
